>>> hdl/asfc_pkg.sv
// Shared types, constants and helpers for the audio sample format converter.
package asfc_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_SOURCE_FORMAT = 3'd0,
    REG_OUT_FLOAT     = 3'd1,
    REG_OUT_CHANNELS  = 3'd2,
    REG_GAIN_ENABLE   = 3'd3,
    REG_GAIN          = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic [1:0]        source_format;
    logic              out_float;
    logic [1:0]        out_channels;
    logic              gain_enable;
    logic signed [15:0] gain;
  } cfg_t;

  localparam int CFG_DATA_W = 16;
  localparam int MAG_W      = 29;          // |value| <= 2^28 in Q28 units
  localparam int MSB_W      = 5;
  localparam int GAIN_FRAC  = 12;          // Q3.12 gain

  localparam logic [1:0]        SRC_FORMAT_RST  = 2'd2;
  localparam logic [1:0]        OUT_CHANNELS_RST = 2'd2;
  localparam logic [1:0]        OUT_CHANNELS_MONO = 2'd1;
  localparam logic signed [15:0] GAIN_UNITY     = 16'sd4096;
  localparam logic signed [15:0] GAIN_ZERO      = 16'sd0;
  localparam logic signed [32:0] INT16_MAX      = 33'sd32767;
  localparam logic signed [32:0] INT16_MIN      = -33'sd32768;
  localparam logic signed [32:0] ONE_Q28        = 33'sd268435456;
  localparam logic signed [32:0] ROUND_TO_ZERO  = 33'sd4095;
  // exponent = msb - 28 + 127
  localparam logic [7:0]        EXP_OFFSET      = 8'd99;

  // Raw sample to int16 domain: 8-bit is offset binary scaled by 256.
  function automatic logic signed [15:0] to_int16(input logic [15:0] raw,
                                                  input logic is8);
    logic signed [15:0] res;
    if (is8) res = {~raw[7], raw[6:0], 8'h00};
    else     res = raw;
    return res;
  endfunction

  // Position of the leading one (0 when the word is zero).
  function automatic logic [MSB_W-1:0] msb_index(input logic [MAG_W-1:0] mag);
    logic [MSB_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (mag[i]) idx = MSB_W'(i);
    end
    return idx;
  endfunction

endpackage

>>> hdl/asfc_cfg.sv
// Configuration register bank with its write channel.
module asfc_cfg
  import asfc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [2:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.source_format <= SRC_FORMAT_RST;
      cfg.out_float     <= 1'b0;
      cfg.out_channels  <= OUT_CHANNELS_RST;
      cfg.gain_enable   <= 1'b1;
      cfg.gain          <= GAIN_UNITY;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_index_t'(cfg_index))
        REG_SOURCE_FORMAT: cfg.source_format <= cfg_data[1:0];
        REG_OUT_FLOAT:     cfg.out_float     <= cfg_data[0];
        REG_OUT_CHANNELS:  cfg.out_channels  <= cfg_data[1:0];
        REG_GAIN_ENABLE:   cfg.gain_enable   <= cfg_data[0];
        REG_GAIN:          cfg.gain          <= $signed(cfg_data);
        default: ;  // unknown index: ignored
      endcase
    end
  end

endmodule

>>> hdl/asfc_lane.sv
// One output channel: gain multiply, int16 clip or float32 packing.
module asfc_lane
  import asfc_pkg::*;
(
  input  logic signed [16:0] operand,    // int16 value, or float value in 2^-16 units
  input  logic               out_float,
  input  logic               apply_gain,
  input  logic signed [15:0] gain,
  output logic [31:0]        result
);

  logic signed [32:0]  prod;
  logic signed [32:0]  prod_adj;
  logic signed [32:0]  quot;
  logic [15:0]         int_val;
  logic signed [32:0]  fixed;
  logic [MAG_W-1:0]    mag;
  logic [MSB_W-1:0]    msb;
  logic [MAG_W-1:0]    norm;
  logic [31:0]         float_bits;

  assign prod = operand * gain;

  // int16: divide by 4096 truncating toward zero, then clip
  assign prod_adj = prod + (prod[32] ? ROUND_TO_ZERO : 33'sd0);
  assign quot     = prod_adj >>> GAIN_FRAC;

  always_comb begin
    if (!apply_gain)            int_val = operand[15:0];
    else if (quot > INT16_MAX)  int_val = 16'h7FFF;
    else if (quot < INT16_MIN)  int_val = 16'h8000;
    else                        int_val = quot[15:0];
  end

  // float: everything in Q28, bypass path scaled up to match
  always_comb begin
    if (!apply_gain)           fixed = {{4{operand[16]}}, operand, 12'b0};
    else if (prod > ONE_Q28)   fixed = ONE_Q28;
    else if (prod < -ONE_Q28)  fixed = -ONE_Q28;
    else                       fixed = prod;
  end

  assign mag  = fixed[32] ? MAG_W'(-fixed) : fixed[MAG_W-1:0];
  assign msb  = msb_index(mag);
  assign norm = mag << (MSB_W'(MAG_W - 1) - msb);

  always_comb begin
    if (mag == '0) float_bits = '0;
    else           float_bits = {fixed[32], 8'(msb) + EXP_OFFSET, norm[MAG_W-2 -: 23]};
  end

  assign result = out_float ? float_bits : {16'b0, int_val};

endmodule

>>> hdl/audio_sample_format_converter_unit.sv
// Top level of the PCM sample format converter with gain.
//
// Input channel (in_valid / in_stall) carries one raw frame: sample_left,
// sample_right and frame_last. Output channel (out_valid / out_stall)
// returns one converted frame per input frame: out_left, out_right
// (int16 in the low half, or float32 bits) and out_last.
// The configuration channel (cfg_valid / cfg_ready, cfg_index, cfg_data)
// writes registers 0..4; cfg_ready is always high, unknown indexes are
// dropped. Write configuration only while no frame is in flight.
// A transferred frame goes into the input register, through one pass of logic,
// and into the result register, which drives the outputs.
// Throughput: one frame per cycle while the result is not stalled; the rate is
// set by the two-register pipeline, each lane holding one 17x16 multiplier.
// Stall: while the result waits, one more frame is taken into the input
// register; in_stall rises only when both registers are full and the
// result is stalled.
// Reset (rst, synchronous): both pipeline stages empty, registers back
// to 16-bit mono source, int16 stereo output, gain enabled at unity.
module audio_sample_format_converter_unit
  import asfc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // input frames
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [15:0]           sample_left,
  input  logic [15:0]           sample_right,
  input  logic                  frame_last,
  // output frames
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [31:0]           out_left,
  output logic [31:0]           out_right,
  output logic                  out_last,
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [2:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg;

  // input register
  logic        s1_valid;
  logic [15:0] s1_left;
  logic [15:0] s1_right;
  logic        s1_last;

  logic in_xfer;
  logic out_adv;

  logic               is8;
  logic               src_stereo;
  logic               out_mono;
  logic               apply_gain;
  logic               silence;
  logic signed [15:0] xl;
  logic signed [15:0] xr;
  logic signed [16:0] sum;
  logic [16:0]        sum_adj;
  logic signed [15:0] avg;
  logic signed [16:0] left_op;
  logic signed [16:0] right_op;
  logic [31:0]        left_res;
  logic [31:0]        right_res;
  logic [31:0]        out_left_next;
  logic [31:0]        out_right_next;

  assign cfg_ready = 1'b1;

  asfc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Handshake: result register frees when it is empty or its transfer completes
  assign out_adv  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !out_adv;
  assign in_xfer  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_xfer) begin
      s1_valid <= 1'b1;
    end else if (out_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_left  <= sample_left;
      s1_right <= sample_right;
      s1_last  <= frame_last;
    end
  end

  // Source decode and channel mixing
  assign is8        = ~cfg.source_format[1];
  assign src_stereo = cfg.source_format[0];
  assign out_mono   = (cfg.out_channels == OUT_CHANNELS_MONO);
  assign apply_gain = cfg.gain_enable && (cfg.gain != GAIN_UNITY);
  assign silence    = cfg.gain_enable && (cfg.gain == GAIN_ZERO);

  assign xl = to_int16(s1_left, is8);
  assign xr = src_stereo ? to_int16(s1_right, is8) : xl;

  // sum is also the exact float mono mix (2*xl for a mono source)
  assign sum     = {xl[15], xl} + {xr[15], xr};
  assign sum_adj = sum + {16'b0, sum[16]};   // halve toward zero
  assign avg     = sum_adj[16:1];

  assign left_op  = cfg.out_float ? (out_mono ? sum : {xl, 1'b0})
                                  : (out_mono ? {avg[15], avg} : {xl[15], xl});
  assign right_op = cfg.out_float ? {xr, 1'b0} : {xr[15], xr};

  asfc_lane u_lane_left (
    .operand    (left_op),
    .out_float  (cfg.out_float),
    .apply_gain (apply_gain),
    .gain       (cfg.gain),
    .result     (left_res)
  );

  asfc_lane u_lane_right (
    .operand    (right_op),
    .out_float  (cfg.out_float),
    .apply_gain (apply_gain),
    .gain       (cfg.gain),
    .result     (right_res)
  );

  assign out_left_next  = silence ? '0 : left_res;
  assign out_right_next = (silence || out_mono) ? '0 : right_res;

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv) begin
      out_left  <= out_left_next;
      out_right <= out_right_next;
      out_last  <= s1_last;
    end
  end

  // Input side only stalls with a frame held in the input register
  a_stall_needs_frame: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid))
    else $error("in_stall without a held frame");

  // Silence forces all-zero output bits
  a_silence: assert property (@(posedge clk) disable iff (rst)
    (out_adv && silence) |=> (out_left == '0 && out_right == '0))
    else $error("silence gain gave non-zero output");

  // int16 output keeps the upper halves clear
  a_int_upper: assert property (@(posedge clk) disable iff (rst)
    (out_adv && !cfg.out_float) |=> (out_left[31:16] == '0 && out_right[31:16] == '0))
    else $error("int16 output with upper bits set");

endmodule

>>> verif/tb_audio_sample_format_converter_unit.sv
// Self-checking testbench for the PCM sample format converter with gain.
module tb_audio_sample_format_converter_unit;
  import asfc_pkg::*;

  localparam int CLK_HALF       = 6;
  localparam int RST_CYCLES     = 2;
  localparam int IDLE_MAX       = 4;
  localparam int HOLD_CYCLES    = 40;     // long receiver hold-off
  localparam int QUIET_LIMIT    = 1000;   // cycles with no transfer at all
  localparam int DRAIN_CYCLES   = 4;      // two-register pipeline, plus margin
  localparam int REPORT_MAX     = 10;
  localparam int RAND_PHASES    = 24;
  localparam int PHASE_FRAMES   = 80;
  localparam int PRESSURE_PHASE = 3;
  // float values are built from integers in units of 2^-16, or 2^-28 with gain
  localparam int FRAC_PLAIN     = 16;
  localparam int FRAC_GAIN      = FRAC_PLAIN + GAIN_FRAC;
  localparam logic [2:0] REG_SPARE = 3'd7;  // no register behind this index

  typedef struct packed {
    logic [31:0] left_v;
    logic [31:0] right_v;
    logic        end_mark;
  } pcm_frame_t;

  // Holds a private copy of the registers, works out the converted frame for
  // every input transfer and compares output transfers in order.
  class frame_scoreboard;
    logic [1:0]         src_fmt;
    logic               flt_out;
    logic [1:0]         chans;
    logic               gain_on;
    logic signed [15:0] gain;
    pcm_frame_t         converted_q[$];
    int                 errors;
    int                 mismatches;

    function new();
      src_fmt    = SRC_FORMAT_RST;
      flt_out    = 1'b0;
      chans      = OUT_CHANNELS_RST;
      gain_on    = 1'b1;
      gain       = GAIN_UNITY;
      errors     = 0;
      mismatches = 0;
    endfunction

    function int pending();
      return converted_q.size();
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] data);
      case (idx)
        REG_SOURCE_FORMAT: src_fmt = data[1:0];
        REG_OUT_FLOAT:     flt_out = data[0];
        REG_OUT_CHANNELS:  chans   = data[1:0];
        REG_GAIN_ENABLE:   gain_on = data[0];
        REG_GAIN:          gain    = data;
        default: ;
      endcase
    endfunction

    // 8-bit sources are offset binary, scaled up into the int16 range
    function int pcm_level(logic [15:0] raw, bit is8);
      if (is8) return (int'(raw[7:0]) - 128) * 256;
      return int'($signed(raw));
    endfunction

    // num * 2^-frac as float32, mantissa truncated (never rounded)
    function logic [31:0] float_bits(longint num, int frac);
      logic [31:0]     sgn;
      longint unsigned mag;
      int              msb;
      int              bexp;
      if (num == 0) return 32'h0;
      sgn = (num < 0) ? 32'h8000_0000 : 32'h0;
      mag = (num < 0) ? -num : num;
      msb = 0;
      while (msb < 63 && (mag >> (msb + 1)) != 0) msb++;
      if (msb > 23) mag = mag >> (msb - 23);
      else          mag = mag << (23 - msb);
      bexp = msb - frac + 127;
      return sgn | (32'(bexp) << 23) | 32'(mag & 64'h7F_FFFF);
    endfunction

    function logic [31:0] int16_out(int x);
      int p;
      p = x;
      if (gain_on && gain != GAIN_UNITY) begin
        p = (x * int'(gain)) / int'(GAIN_UNITY);
        if (p > int'(INT16_MAX)) p = int'(INT16_MAX);
        if (p < int'(INT16_MIN)) p = int'(INT16_MIN);
      end
      return {16'h0, p[15:0]};
    endfunction

    function logic [31:0] float_out(int v);
      longint p;
      if (gain_on && gain != GAIN_UNITY) begin
        p = longint'(v) * longint'(gain);
        if (p > longint'(ONE_Q28))  p = longint'(ONE_Q28);
        if (p < -longint'(ONE_Q28)) p = -longint'(ONE_Q28);
        return float_bits(p, FRAC_GAIN);
      end
      return float_bits(longint'(v), FRAC_PLAIN);
    endfunction

    function void note_frame(logic [15:0] l_raw, logic [15:0] r_raw, logic eob);
      bit         is8;
      bit         st_in;
      bit         mono_out;
      int         xl;
      int         xr;
      pcm_frame_t f;
      is8      = !src_fmt[1];
      st_in    = src_fmt[0];
      mono_out = (chans == OUT_CHANNELS_MONO);
      xl       = pcm_level(l_raw, is8);
      xr       = st_in ? pcm_level(r_raw, is8) : xl;
      f        = '0;
      f.end_mark = eob;
      if (gain_on && gain == GAIN_ZERO) begin
        // silence: both slots stay zero
      end else if (flt_out) begin
        if (mono_out) begin
          f.left_v = float_out(st_in ? xl + xr : 2 * xl);
        end else begin
          f.left_v  = float_out(2 * xl);
          f.right_v = float_out(2 * xr);
        end
      end else begin
        if (mono_out) begin
          f.left_v = int16_out(st_in ? (xl + xr) / 2 : xl);
        end else begin
          f.left_v  = int16_out(xl);
          f.right_v = int16_out(xr);
        end
      end
      converted_q.insert(converted_q.size(), f);
    endfunction

    function void check_frame(logic [31:0] l_got, logic [31:0] r_got, logic eob_got);
      pcm_frame_t want;
      errors++;
      if (converted_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected output frame: left %h right %h last %b",
                   l_got, r_got, eob_got);
        return;
      end
      want = converted_q.pop_front();
      if (want.left_v === l_got && want.right_v === r_got && want.end_mark === eob_got) begin
        errors--;
        return;
      end
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display("frame mismatch: expected left %h right %h last %b, got left %h right %h last %b",
                 want.left_v, want.right_v, want.end_mark, l_got, r_got, eob_got);
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [15:0] sample_left;
  logic [15:0] sample_right;
  logic        frame_last;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_left;
  logic [31:0] out_right;
  logic        out_last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  frame_scoreboard sb;
  bit              tx_idle;   // sender inserts random gaps
  bit              rx_idle;   // receiver stalls at random
  bit              hold_req;  // ask the receiver for one long hold-off

  audio_sample_format_converter_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .sample_left  (sample_left),
    .sample_right (sample_right),
    .frame_last   (frame_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_left     (out_left),
    .out_right    (out_right),
    .out_last     (out_last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Monitors sample at the rising edge. Register writes update the private
  // copy, input transfers queue a prediction, output transfers are checked.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) sb.note_frame(sample_left, sample_right, frame_last);
      if (out_valid && !out_stall) sb.check_frame(out_left, out_right, out_last);
    end
  end

  // Receiver: per frame a random number of stalled cycles, then ready until
  // a transfer happens. On request it holds off for a long stretch first so
  // that both pipeline registers fill and the input side stalls.
  initial begin : rx_side
    int wait_n;
    out_stall = 1'b1;
    @(negedge clk);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      wait_n = rx_idle ? $urandom_range(0, IDLE_MAX) : 0;
      if (wait_n > 0) begin
        out_stall <= 1'b1;
        repeat (wait_n) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // Watchdog: a hang shows up as a long run of cycles without any transfer.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("audio_sample_format_converter_unit verification failed");
        $finish;
      end
    end
  end

  // Offers one frame after a random gap; returns just after its transfer edge.
  // valid is only ever raised or lowered once per falling edge.
  task automatic send_frame(input logic [15:0] l_raw, input logic [15:0] r_raw,
                            input logic eob);
    int gap;
    gap = tx_idle ? $urandom_range(0, IDLE_MAX) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    sample_left  <= l_raw;
    sample_right <= r_raw;
    frame_last   <= eob;
    do @(posedge clk); while (in_stall);
  endtask

  // Stop offering frames and wait until every predicted frame has come back,
  // so the block is idle before the next register write.
  task automatic end_frames();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Narrow registers get junk in the unused upper bits of the write data.
  task automatic apply_settings(input logic [1:0] fmt, input logic flt,
                                input logic [1:0] ch, input logic g_on,
                                input logic [15:0] g);
    write_reg(REG_SOURCE_FORMAT, {14'($urandom), fmt});
    write_reg(REG_OUT_FLOAT,     {15'($urandom), flt});
    write_reg(REG_OUT_CHANNELS,  {14'($urandom), ch});
    write_reg(REG_GAIN_ENABLE,   {15'($urandom), g_on});
    write_reg(REG_GAIN,          g);
    if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE, 16'($urandom));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Raw samples lean towards the ends of both the 8-bit and 16-bit ranges.
  function automatic logic [15:0] pick_raw();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h7FFF;
      3:       return 16'h8000;
      4:       return {8'($urandom), 8'h80};
      5:       return {8'($urandom), 8'h7F};
      6:       return {8'($urandom), 8'h00};
      7:       return {8'($urandom), 8'hFF};
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(0, 9))
      0:       return GAIN_ZERO;
      1, 2:    return GAIN_UNITY;
      3:       return 16'sh7FFF;
      4:       return 16'sh8000;
      5:       return -GAIN_UNITY;
      6:       return 16'($urandom_range(1, 8191));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic run_frames(input int n);
    repeat (n) send_frame(pick_raw(), pick_raw(), 1'($urandom));
    end_frames();
  endtask

  initial begin : stimulus
    sb           = new();
    tx_idle      = 1'b1;
    rx_idle      = 1'b1;
    hold_req     = 1'b0;
    rst          = 1'b1;
    in_valid     = 1'b0;
    sample_left  = '0;
    sample_right = '0;
    frame_last   = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    repeat (RST_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: 16-bit mono in, int16 stereo out, unity bypass.
    send_frame(16'h0000, 16'hFFFF, 1'b0);
    send_frame(16'h7FFF, 16'h8000, 1'b1);
    send_frame(16'h8000, 16'h7FFF, 1'b0);
    send_frame(16'hFFFF, 16'h0001, 1'b1);
    end_frames();

    // 8-bit stereo averaged to mono, top gain saturates; upper bytes are junk.
    apply_settings(2'd1, 1'b0, OUT_CHANNELS_MONO, 1'b1, 16'sh7FFF);
    send_frame(16'hFF00, 16'h00FF, 1'b0);
    send_frame(16'h00FF, 16'h00FF, 1'b1);
    send_frame(16'hA580, 16'h5A7F, 1'b0);
    send_frame(16'h1200, 16'h3400, 1'b1);
    end_frames();

    // 8-bit mono duplicated to float stereo, most negative gain clips at -1.
    apply_settings(2'd0, 1'b1, OUT_CHANNELS_RST, 1'b1, 16'sh8000);
    send_frame(16'h00FF, 16'hFFFF, 1'b0);
    send_frame(16'hFF00, 16'h0000, 1'b1);
    send_frame(16'h0080, 16'h1234, 1'b0);
    send_frame(16'hAB7F, 16'h0000, 1'b1);
    end_frames();

    // Gain switched off: zero gain must not silence, float mono mix is exact.
    apply_settings(2'd3, 1'b1, OUT_CHANNELS_MONO, 1'b0, GAIN_ZERO);
    send_frame(16'h7FFF, 16'h7FFF, 1'b0);
    send_frame(16'h8000, 16'h8000, 1'b1);
    send_frame(16'h8000, 16'h7FFF, 1'b0);
    send_frame(16'h0001, 16'hFFFF, 1'b1);
    end_frames();

    // Silence, with a channel count of 0 taken as stereo.
    apply_settings(2'd2, 1'b0, 2'd0, 1'b1, GAIN_ZERO);
    send_frame(16'h7FFF, 16'h1234, 1'b1);
    send_frame(16'h8000, 16'hFFFF, 1'b0);
    end_frames();

    // Channel count of 3 taken as stereo, float at unity.
    apply_settings(2'd1, 1'b1, 2'd3, 1'b1, GAIN_UNITY);
    send_frame(16'h0000, 16'h00FF, 1'b1);
    send_frame(16'h0080, 16'h007F, 1'b0);
    end_frames();

    // Negated gain: full-scale negative flips past the int16 top and clips.
    apply_settings(2'd3, 1'b0, OUT_CHANNELS_MONO, 1'b1, -GAIN_UNITY);
    send_frame(16'h8000, 16'h8000, 1'b0);
    send_frame(16'h7FFF, 16'h8001, 1'b1);
    end_frames();

    // Random settings per phase; some phases run without any idling, and one
    // runs the sender flat out against a long receiver hold-off.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      apply_settings(2'($urandom), 1'($urandom), 2'($urandom),
                     ($urandom_range(0, 4) != 0), pick_gain());
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      if (ph == PRESSURE_PHASE) begin
        tx_idle  = 1'b0;
        hold_req = 1'b1;
      end
      run_frames(PHASE_FRAMES);
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("audio_sample_format_converter_unit verification clean");
    end else begin
      $display("audio_sample_format_converter_unit verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/asfc_pkg.sv
hdl/asfc_cfg.sv
hdl/asfc_lane.sv
hdl/audio_sample_format_converter_unit.sv
verif/tb_audio_sample_format_converter_unit.sv
